// ===== sv/sparse_pattern_merge_gather_macros.svh =====
// assertion macros used by the top rtl file
`ifndef SPARSE_PATTERN_MERGE_GATHER_MACROS_SVH
`define SPARSE_PATTERN_MERGE_GATHER_MACROS_SVH

`ifndef SYNTHESIS
`define SPMG_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);
`define SPMG_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);
`else
`define SPMG_ASSERT_IMP(lbl, ant, con, msg)
`define SPMG_ASSERT_NXT(lbl, ant, con, msg)
`endif

`endif

// ===== sv/spmg_pkg.sv =====
package spmg_pkg;

	localparam int PATTERN_SLOTS = 32;
	localparam int IDX_W = $clog2(PATTERN_SLOTS);
	localparam int CNT_W = $clog2(PATTERN_SLOTS + 1);
	localparam int COL_W = 31;
	localparam int SYS_W = 31;
	localparam int SLOT_W = 5;
	localparam int VAL_W = 64;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [SYS_W-1:0] sys_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [VAL_W-1:0] val_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic in_range;
		logic lt;
		logic eq;
	} cmp_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		cnt_t wcount;
		col_t wdata;
	} store_wr_t;

endpackage

// ===== sv/spmg_if.sv =====
interface spmg_in_if;
	logic valid;
	logic ready;
	logic req_type;
	spmg_pkg::slot_t slot;
	spmg_pkg::col_t column_index;
	spmg_pkg::val_t value_real;
	spmg_pkg::val_t value_imag;
	logic first_of_column;
	spmg_pkg::sys_t system_index;
	spmg_pkg::slot_t column_position;

	modport source (
		output valid, req_type, slot, column_index, value_real, value_imag,
		first_of_column, system_index, column_position,
		input ready
	);
	modport sink (
		input valid, req_type, slot, column_index, value_real, value_imag,
		first_of_column, system_index, column_position,
		output ready
	);
endinterface

interface spmg_out_if;
	logic valid;
	logic ready;
	spmg_pkg::sys_t out_system;
	spmg_pkg::slot_t out_column_slot;
	spmg_pkg::slot_t out_row_slot;
	spmg_pkg::val_t out_value_real;
	spmg_pkg::val_t out_value_imag;

	modport source (
		output valid, out_system, out_column_slot, out_row_slot, out_value_real,
		out_value_imag,
		input ready
	);
	modport sink (
		input valid, out_system, out_column_slot, out_row_slot, out_value_real,
		out_value_imag,
		output ready
	);
endinterface

// ===== sv/spmg_store.sv =====
module spmg_store (
	input logic clk,
	input logic arst_n,
	input spmg_pkg::store_wr_t wr,
	input spmg_pkg::idx_t raddr,
	output spmg_pkg::col_t rdata,
	output spmg_pkg::cnt_t count
);

	spmg_pkg::col_t pat_q [spmg_pkg::PATTERN_SLOTS];
	spmg_pkg::cnt_t count_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			pat_q[wr.waddr] <= wr.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.we) begin
			count_q <= wr.wcount;
		end
	end

	// the read address width matches the depth, so addresses past it never occur
	always_comb begin
		if (int'(raddr) < spmg_pkg::PATTERN_SLOTS) begin
			rdata = pat_q[raddr];
		end else begin
			rdata = '0;
		end
	end

	assign count = count_q;

endmodule

// ===== sv/spmg_cmp.sv =====
module spmg_cmp (
	input spmg_pkg::cnt_t ptr,
	input spmg_pkg::cnt_t count,
	input spmg_pkg::col_t pat,
	input spmg_pkg::col_t key,
	output spmg_pkg::cmp_t res
);

	always_comb begin
		res.in_range = (ptr < count);
		res.lt = (pat < key);
		res.eq = (pat == key);
	end

endmodule

// ===== sv/sparse_pattern_merge_gather.sv =====
// load item: accepted in the idle state, the pattern slot is written at that edge
// matrix item: accepted in idle, then the scan steps over k skipped pattern slots, one compare per cycle
// in the shared compare unit; a match then moves into the output register through the emit state,
// which waits while the previous result is still held there
// reset clears the sequencer, pointer, latches, count and output valid;
// the pattern slots are not cleared
`include "sparse_pattern_merge_gather_macros.svh"

module sparse_pattern_merge_gather (
	input logic clk,
	input logic arst_n,
	spmg_in_if.sink entry,
	spmg_out_if.source result
);

	spmg_pkg::state_t state_q, state_nxt;
	spmg_pkg::cnt_t ptr_q;
	spmg_pkg::sys_t sys_q;
	spmg_pkg::slot_t cpos_q;
	spmg_pkg::col_t key_q;
	spmg_pkg::val_t vre_q, vim_q;

	logic out_valid_q;
	spmg_pkg::sys_t out_sys_q;
	spmg_pkg::slot_t out_cpos_q, out_row_q;
	spmg_pkg::val_t out_vre_q, out_vim_q;

	spmg_pkg::store_wr_t wr;
	spmg_pkg::col_t pat_rd;
	spmg_pkg::cnt_t count;
	spmg_pkg::cmp_t cmp;

	logic in_ready, accept, take_entry, ptr_step, out_free, out_load;

	spmg_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.raddr(spmg_pkg::idx_t'(ptr_q)),
		.rdata(pat_rd),
		.count(count)
	);

	spmg_cmp u_cmp (
		.ptr(ptr_q),
		.count(count),
		.pat(pat_rd),
		.key(key_q),
		.res(cmp)
	);

	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spmg_pkg::ST_IDLE: begin
				if (entry.valid && entry.req_type == spmg_pkg::REQ_ENTRY) begin
					state_nxt = spmg_pkg::ST_SCAN;
				end
			end
			spmg_pkg::ST_SCAN: begin
				if (cmp.in_range && cmp.lt) begin
					state_nxt = spmg_pkg::ST_SCAN;
				end else if (cmp.in_range && cmp.eq) begin
					state_nxt = spmg_pkg::ST_EMIT;
				end else begin
					state_nxt = spmg_pkg::ST_IDLE;
				end
			end
			spmg_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = spmg_pkg::ST_IDLE;
				end
			end
			default: state_nxt = spmg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == spmg_pkg::ST_IDLE);
		accept = entry.valid && in_ready;
		take_entry = accept && entry.req_type == spmg_pkg::REQ_ENTRY;
		wr.we = accept && entry.req_type == spmg_pkg::REQ_LOAD
			&& int'(entry.slot) < spmg_pkg::PATTERN_SLOTS;
		wr.waddr = spmg_pkg::idx_t'(entry.slot);
		wr.wcount = spmg_pkg::cnt_t'(int'(entry.slot) + 1);
		wr.wdata = entry.column_index;
		out_load = (state_q == spmg_pkg::ST_EMIT) && out_free;
		ptr_step = ((state_q == spmg_pkg::ST_SCAN) && cmp.in_range && cmp.lt) || out_load;
	end

	assign entry.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spmg_pkg::ST_IDLE;
			ptr_q <= '0;
			sys_q <= '0;
			cpos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (take_entry && entry.first_of_column) begin
				ptr_q <= '0;
				sys_q <= entry.system_index;
				cpos_q <= entry.column_position;
			end else if (ptr_step) begin
				ptr_q <= ptr_q + spmg_pkg::cnt_t'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_entry) begin
			key_q <= entry.column_index;
			vre_q <= entry.value_real;
			vim_q <= entry.value_imag;
		end
		if (out_load) begin
			out_sys_q <= sys_q;
			out_cpos_q <= cpos_q;
			out_row_q <= spmg_pkg::slot_t'(ptr_q);
			out_vre_q <= vre_q;
			out_vim_q <= vim_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_system = out_sys_q;
	assign result.out_column_slot = out_cpos_q;
	assign result.out_row_slot = out_row_q;
	assign result.out_value_real = out_vre_q;
	assign result.out_value_imag = out_vim_q;

	// a held match must still be a match on the unchanged pointer and key
	`SPMG_ASSERT_IMP(a_emit_match, state_q == spmg_pkg::ST_EMIT, cmp.in_range && cmp.eq, "emit without match")
	`SPMG_ASSERT_NXT(a_scan_done, state_q == spmg_pkg::ST_SCAN && !cmp.in_range, state_q == spmg_pkg::ST_IDLE, "scan past count")
	`SPMG_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q) == spmg_pkg::ST_EMIT, "result not from emit")

endmodule

// ===== verif/spmg_gather_monitor.sv =====
module spmg_gather_monitor (
	input logic clk,
	input logic arst_n,
	spmg_in_if entry,
	spmg_out_if result,
	output int fail_count,
	output int pending_gathers,
	output int gathers_checked
);
	import spmg_pkg::*;

	typedef struct packed {
		sys_t sys;
		slot_t col_slot;
		slot_t row_slot;
		val_t re;
		val_t im;
	} gather_t;

	col_t pat_store [PATTERN_SLOTS];
	cnt_t pat_count;
	cnt_t walk_ptr;
	sys_t cur_sys;
	slot_t cur_col_slot;
	gather_t gather_q [$];

	initial begin
		fail_count = 0;
		pending_gathers = 0;
		gathers_checked = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// one accepted item through the merge: loads write the pattern, entries walk it
	task automatic merge_item();
		gather_t g;
		if (entry.req_type == REQ_LOAD) begin
			// loads past the last slot leave the pattern alone
			if (int'(entry.slot) < PATTERN_SLOTS) begin
				pat_store[idx_t'(entry.slot)] = entry.column_index;
				pat_count = cnt_t'(entry.slot) + cnt_t'(1);
			end
		end else begin
			if (entry.first_of_column) begin
				walk_ptr = '0;
				cur_sys = entry.system_index;
				cur_col_slot = entry.column_position;
			end
			while (walk_ptr < pat_count && pat_store[idx_t'(walk_ptr)] < entry.column_index)
				walk_ptr++;
			if (walk_ptr < pat_count && pat_store[idx_t'(walk_ptr)] == entry.column_index) begin
				g.sys = cur_sys;
				g.col_slot = cur_col_slot;
				g.row_slot = slot_t'(walk_ptr);
				g.re = entry.value_real;
				g.im = entry.value_imag;
				gather_q.push_back(g);
				walk_ptr++;
			end
		end
	endtask

	task automatic check_gather();
		gather_t g;
		if (gather_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result system %0h row %0d",
				result.out_system, result.out_row_slot));
		end else begin
			g = gather_q.pop_front();
			gathers_checked++;
			if (result.out_system !== g.sys)
				report_mismatch($sformatf("out_system %0h, wanted %0h",
					result.out_system, g.sys));
			if (result.out_column_slot !== g.col_slot)
				report_mismatch($sformatf("out_column_slot %0d, wanted %0d",
					result.out_column_slot, g.col_slot));
			if (result.out_row_slot !== g.row_slot)
				report_mismatch($sformatf("out_row_slot %0d, wanted %0d",
					result.out_row_slot, g.row_slot));
			if (result.out_value_real !== g.re)
				report_mismatch($sformatf("out_value_real %0h, wanted %0h",
					result.out_value_real, g.re));
			if (result.out_value_imag !== g.im)
				report_mismatch($sformatf("out_value_imag %0h, wanted %0h",
					result.out_value_imag, g.im));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_count = '0;
			walk_ptr = '0;
			cur_sys = '0;
			cur_col_slot = '0;
			gather_q.delete();
		end else begin
			if (entry.valid && entry.ready)
				merge_item();
			if (result.valid && result.ready)
				check_gather();
		end
		pending_gathers = gather_q.size();
	end

endmodule

// ===== verif/sparse_pattern_merge_gather_tb.sv =====
module sparse_pattern_merge_gather_tb;
	import spmg_pkg::*;

	localparam int RANDOM_ITEMS = 1900;

	logic clk;
	logic arst_n;

	spmg_in_if entry_ch ();
	spmg_out_if result_ch ();

	int fail_count;
	int pending_gathers;
	int gathers_checked;

	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int entries_sent = 0;

	// what the stimulus knows of the pattern, so that entries never reach an unwritten slot
	col_t pat_mirror [PATTERN_SLOTS];
	int pat_len = 0;
	int filled_to = 0;

	sparse_pattern_merge_gather DUT (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_ch),
		.result(result_ch)
	);

	spmg_gather_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.pending_gathers(pending_gathers),
		.gathers_checked(gathers_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#(20 * 1000000);
		$display("timeout: stimulus or results stuck");
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(input logic req, input slot_t slot, input col_t col,
			input logic first, input sys_t sys, input slot_t cpos, input val_t re, input val_t im);
		while ($urandom_range(99) < idle_pct) begin
			entry_ch.valid <= 1'b0;
			@(negedge clk);
		end
		entry_ch.valid <= 1'b1;
		entry_ch.req_type <= req;
		entry_ch.slot <= slot;
		entry_ch.column_index <= col;
		entry_ch.first_of_column <= first;
		entry_ch.system_index <= sys;
		entry_ch.column_position <= cpos;
		entry_ch.value_real <= re;
		entry_ch.value_imag <= im;
		@(posedge clk);
		while (!entry_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_load(input slot_t slot, input col_t col);
		send_item(REQ_LOAD, slot, col, 1'($urandom), sys_t'($urandom), slot_t'($urandom),
			{$urandom, $urandom}, {$urandom, $urandom});
		loads_sent++;
		pat_mirror[slot] = col;
		pat_len = int'(slot) + 1;
		if (int'(slot) == filled_to)
			filled_to++;
	endtask

	task automatic send_entry(input logic first, input col_t col, input sys_t sys,
			input slot_t cpos, input val_t re, input val_t im);
		send_item(REQ_ENTRY, slot_t'($urandom), col, first, sys, cpos, re, im);
		entries_sent++;
	endtask

	// lower valid and hold off until every gathered value has come out
	task automatic drain();
		entry_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_gathers != 0)
			@(negedge clk);
	endtask

	task automatic load_pattern(input int n);
		int vals [$];
		int lo;
		int span;
		case ($urandom_range(3))
			0: begin
				lo = 0;
				span = 63;
			end
			1: begin
				lo = $urandom_range(1 << 24);
				span = 1 << 16;
			end
			2: begin
				lo = 0;
				span = 32'h7FFF_FFFF;
			end
			default: begin
				lo = 32'h7FFF_FFFF - 4095;
				span = 4095;
			end
		endcase
		for (int i = 0; i < n; i++)
			vals.push_back(lo + int'($urandom_range(span)));
		// now and then the pattern is left unsorted
		if ($urandom_range(9) != 0)
			vals.sort();
		for (int i = 0; i < n; i++)
			send_load(slot_t'(i), col_t'(vals[i]));
	endtask

	task automatic next_walk_col(inout int pidx, output col_t c);
		int r;
		r = $urandom_range(99);
		if (pidx < pat_len && r < 55) begin
			c = pat_mirror[pidx];
			pidx++;
		end else if (pidx < pat_len && r < 70) begin
			// falls between slots, usually a miss
			c = pat_mirror[pidx] + col_t'(1);
			pidx++;
		end else if (pidx + 1 < pat_len && r < 80) begin
			pidx += 2;
			c = pat_mirror[pidx - 1];
		end else if (r < 90) begin
			c = col_t'($urandom_range(63));
		end else begin
			c = col_t'($urandom);
		end
	endtask

	task automatic run_group();
		int r;
		int n;
		int m;
		int pidx;
		logic broken;
		logic first;
		col_t c;
		r = $urandom_range(99);
		if (r < 10 || pat_len == 0) begin
			n = ($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(32, 9);
			load_pattern(n);
		end else if (r < 15) begin
			n = (filled_to > 31) ? 31 : filled_to;
			send_load(slot_t'($urandom_range(n, 0)),
				($urandom_range(1) == 0) ? col_t'($urandom_range(63)) : col_t'($urandom));
		end else begin
			broken = ($urandom_range(99) < 8);
			m = $urandom_range(10, 1);
			pidx = 0;
			for (int i = 0; i < m; i++) begin
				first = (i == 0 && !broken) || ($urandom_range(99) < 3);
				if (first)
					pidx = 0;
				next_walk_col(pidx, c);
				send_entry(first, c, sys_t'($urandom), slot_t'($urandom),
					{$urandom, $urandom}, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		entry_ch.valid = 1'b0;
		entry_ch.req_type = REQ_LOAD;
		entry_ch.slot = '0;
		entry_ch.column_index = '0;
		entry_ch.first_of_column = 1'b0;
		entry_ch.system_index = '0;
		entry_ch.column_position = '0;
		entry_ch.value_real = '0;
		entry_ch.value_imag = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// entry with an empty pattern
		send_entry(1'b0, col_t'(5), '0, '0, '0, '0);
		send_load(slot_t'(0), '0);
		send_load(slot_t'(1), '1);
		// no first entry yet: reset latches are used
		send_entry(1'b0, '0, '1, '1, '0, '0);
		send_entry(1'b1, '1, '1, '1, '1, '1);
		// pointer exhausted
		send_entry(1'b0, '1, '0, '0, '1, '0);
		send_entry(1'b1, col_t'(5), '0, '0, '0, '1);
		// unsorted pattern: 0, max, 3
		send_load(slot_t'(2), col_t'(3));
		send_entry(1'b1, col_t'(3), sys_t'(123), '1, {$urandom, $urandom}, '0);
		send_entry(1'b0, '1, '0, '0, {$urandom, $urandom}, '1);
		send_entry(1'b0, col_t'(3), '0, '0, '1, {$urandom, $urandom});
		// reload of slot 0 shrinks the pattern to one slot
		send_load(slot_t'(0), col_t'(9));
		send_entry(1'b1, col_t'(9), sys_t'(7), slot_t'(30), '1, '1);
		send_entry(1'b0, col_t'(9), '0, '0, '0, '0);
		send_entry(1'b1, col_t'(8), '1, '0, '0, '0);
		send_entry(1'b0, col_t'(10), '0, '0, '1, '1);
		// duplicate indices match on successive slots
		send_load(slot_t'(0), col_t'(4));
		send_load(slot_t'(1), col_t'(4));
		send_entry(1'b1, col_t'(4), sys_t'(1), slot_t'(1), '0, '1);
		send_entry(1'b0, col_t'(4), '0, '0, '1, '0);
		send_entry(1'b0, col_t'(4), '0, '0, '1, '1);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 51;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 51;
				end
				default: begin
					idle_pct = 15;
					stall_pct = 15;
				end
			endcase
			while (items_sent < 21 + (phase + 1) * RANDOM_ITEMS / 4)
				run_group();
			drain();
		end

		stall_pct = 0;
		repeat (60) @(negedge clk);

		$display("%0d items driven: %0d pattern loads, %0d matrix entries; %0d gathered values checked",
			items_sent, loads_sent, entries_sent, gathers_checked);
		$display("corner cases first, then random walks with no gaps, sender gaps, receiver stalls, both");
		if (fail_count == 0 && pending_gathers == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
